[hw/rtl/qslp_pkg.sv]
// Shared types, widths and constants for the quaternion slerp pipeline.
// Used by every module under hw/rtl; depends on nothing else.
package qslp_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 24;

  localparam int COMP_W   = 16;   // input component, Q1.14
  localparam int QN_W     = 17;   // negated component can reach +32768
  localparam int BLEND_W  = 20;   // blend, Q5.14
  localparam int OUT_W    = 20;   // output component, Q5.14
  localparam int THR_W    = 15;
  localparam int C_W      = 15;   // cosine 0..16384
  localparam int DOT_W    = 34;
  localparam int FRAC     = 14;
  localparam int ONE_Q14  = 16384;
  localparam int ROOT_W   = 31;
  localparam int RAD_W    = 62;
  localparam int VEC_W    = 34;
  localparam int ANG_W    = 32;   // omega, Q30
  localparam int PROD_W   = 53;   // blend * omega before the Q14 shift
  localparam int RED_W    = 34;   // reduced angle, Q30
  localparam int SIN_W    = 33;
  localparam int WGT_W    = 26;
  localparam int DIV_BITS = 25;
  localparam int SIN_PRE  = 5;    // reduction stages ahead of the rotation
  localparam int DIV_LAT  = DIV_BITS + 2;
  localparam int WLIM     = 1 << 24;

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint TWO_PI_Q30  = 64'd6746518852;

  typedef struct packed {
    logic                         valid;
    logic [3:0][COMP_W-1:0]       p;
    logic [3:0][QN_W-1:0]         q;
    logic [BLEND_W-1:0]           t;
    logic                         linear;
  } side_t;

  function automatic int steps_used(input int s);
    return (s < CORDIC_MAX) ? s : CORDIC_MAX;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    case (i)
      0:       return 32'sd843314857;
      1:       return 32'sd497837829;
      2:       return 32'sd263043837;
      3:       return 32'sd133525159;
      4:       return 32'sd67021687;
      5:       return 32'sd33543516;
      6:       return 32'sd16775851;
      7:       return 32'sd8388437;
      8:       return 32'sd4194283;
      9:       return 32'sd2097149;
      10:      return 32'sd1048576;
      11:      return 32'sd524288;
      12:      return 32'sd262144;
      13:      return 32'sd131072;
      14:      return 32'sd65536;
      15:      return 32'sd32768;
      16:      return 32'sd16384;
      17:      return 32'sd8192;
      18:      return 32'sd4096;
      19:      return 32'sd2048;
      20:      return 32'sd1024;
      21:      return 32'sd512;
      22:      return 32'sd256;
      23:      return 32'sd128;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

[hw/rtl/qslp_isqrt.sv]
// Pipelined floor square root, one result bit per stage, with a tag
// carried alongside. Depends on qslp_pkg.
module qslp_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qslp_pkg::RAD_W-1:0]   rad,
  input  logic [qslp_pkg::ROOT_W-1:0]  tag_in,
  output logic [qslp_pkg::ROOT_W-1:0]  root,
  output logic [qslp_pkg::ROOT_W-1:0]  tag_out
);
  import qslp_pkg::*;

  logic [RAD_W-1:0]  rem_q  [1:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [1:ROOT_W];
  logic [ROOT_W-1:0] tag_q  [1:ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    localparam int B = ROOT_W - 1 - k;
    logic [RAD_W-1:0]  r_in;
    logic [RAD_W-1:0]  term;
    logic [ROOT_W-1:0] q_in;
    logic [ROOT_W-1:0] t_in;
    logic              take;

    if (k == 0) begin : g_first
      assign r_in = rad;
      assign q_in = '0;
      assign t_in = tag_in;
    end else begin : g_rest
      assign r_in = rem_q[k];
      assign q_in = root_q[k];
      assign t_in = tag_q[k];
    end

    // (r + 2^B)^2 - r^2; the root only has bits above B, so OR is an add
    assign term = (RAD_W'(q_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
    assign take = (r_in >= term);

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k+1] <= take ? (q_in | (ROOT_W'(1) << B)) : q_in;
        tag_q[k+1]  <= t_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1] <= take ? (r_in - term) : r_in;
        end
      end
    end
  end

  assign root    = root_q[ROOT_W];
  assign tag_out = tag_q[ROOT_W];

endmodule

[hw/rtl/qslp_atan.sv]
// Pipelined CORDIC vectoring: angle of a point in the first quadrant, Q30.
// Depends on qslp_pkg.
module qslp_atan #(
  parameter int STEPS = qslp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [qslp_pkg::ROOT_W-1:0]        x_in,
  input  logic [qslp_pkg::ROOT_W-1:0]        y_in,
  output logic signed [qslp_pkg::ANG_W-1:0]  om
);
  import qslp_pkg::*;

  localparam int NS = steps_used(STEPS);

  logic signed [VEC_W-1:0] x_q [1:NS-1];
  logic signed [VEC_W-1:0] y_q [1:NS-1];
  logic signed [ANG_W-1:0] z_q [1:NS];

  for (genvar i = 0; i < NS; i++) begin : g_it
    logic signed [VEC_W-1:0] xi;
    logic signed [VEC_W-1:0] yi;
    logic signed [ANG_W-1:0] zi;
    logic                    up;

    if (i == 0) begin : g_first
      assign xi = $signed(VEC_W'(x_in));
      assign yi = $signed(VEC_W'(y_in));
      assign zi = '0;
    end else begin : g_rest
      assign xi = x_q[i];
      assign yi = y_q[i];
      assign zi = z_q[i];
    end

    assign up = (yi > 0);

    always_ff @(posedge clk) begin
      if (en) begin
        z_q[i+1] <= up ? (zi + atan_q30(i)) : (zi - atan_q30(i));
      end
    end

    if (i < NS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          x_q[i+1] <= up ? (xi + (yi >>> i)) : (xi - (yi >>> i));
          y_q[i+1] <= up ? (yi - (xi >>> i)) : (yi + (xi >>> i));
        end
      end
    end
  end

  assign om = z_q[NS];

endmodule

[hw/rtl/qslp_sin.sv]
// Angle reduction to [-pi/2, pi/2] followed by pipelined CORDIC rotation.
// Takes a Q44 angle product, returns the gain-scaled sine. Depends on qslp_pkg.
module qslp_sin #(
  parameter int STEPS = qslp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qslp_pkg::PROD_W-1:0]  prod,
  output logic signed [qslp_pkg::SIN_W-1:0]   sin
);
  import qslp_pkg::*;

  localparam int NS    = steps_used(STEPS);
  localparam int MAG_W = PROD_W - FRAC - 1;
  localparam logic [MAG_W-1:0] K1 = MAG_W'(TWO_PI_Q30);
  localparam logic [MAG_W-1:0] K2 = MAG_W'(2 * TWO_PI_Q30);
  localparam logic [MAG_W-1:0] K4 = MAG_W'(4 * TWO_PI_Q30);
  localparam logic [MAG_W-1:0] K8 = MAG_W'(8 * TWO_PI_Q30);
  localparam logic signed [RED_W-1:0] PI_R   = RED_W'(PI_Q30);
  localparam logic signed [RED_W-1:0] HPI_R  = RED_W'(HALF_PI_Q30);
  localparam logic signed [RED_W-1:0] TWPI_R = RED_W'(TWO_PI_Q30);
  localparam logic signed [VEC_W-1:0] ONE_Q30 = VEC_W'(1) <<< 30;

  // reduction: floor shift, magnitude, remainder mod 2pi, sign back, wrap, reflect
  logic signed [PROD_W-1:0] a_sh;
  logic signed [PROD_W-1:0] a_abs;
  logic [MAG_W-1:0]         mag0, mag1;
  logic [MAG_W-1:0]         mag1_c, mag2_c, t8, t2;
  logic [RED_W-2:0]         mag2;
  logic                     neg0, neg1, neg2;
  logic signed [RED_W-1:0]  rs, rw, r3, rr, a4;

  assign a_sh  = prod >>> FRAC;
  assign a_abs = a_sh[PROD_W-1] ? -a_sh : a_sh;

  assign t8     = (mag0 >= K8) ? (mag0 - K8) : mag0;
  assign mag1_c = (t8 >= K4) ? (t8 - K4) : t8;
  assign t2     = (mag1 >= K2) ? (mag1 - K2) : mag1;
  assign mag2_c = (t2 >= K1) ? (t2 - K1) : t2;

  assign rs = neg2 ? -$signed({1'b0, mag2}) : $signed({1'b0, mag2});

  always_comb begin
    rw = rs;
    if (rs > PI_R) begin
      rw = rs - TWPI_R;
    end else if (rs < -PI_R) begin
      rw = rs + TWPI_R;
    end
    rr = r3;
    if (r3 > HPI_R) begin
      rr = PI_R - r3;
    end else if (r3 < -HPI_R) begin
      rr = -PI_R - r3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= MAG_W'(a_abs);
      neg0 <= a_sh[PROD_W-1];
      mag1 <= mag1_c;
      neg1 <= neg0;
      mag2 <= mag2_c[RED_W-2:0];
      neg2 <= neg1;
      r3   <= rw;
      a4   <= rr;
    end
  end

  logic signed [VEC_W-1:0] x_q [1:NS-1];
  logic signed [VEC_W-1:0] y_q [1:NS];
  logic signed [RED_W-1:0] z_q [1:NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_it
    logic signed [VEC_W-1:0] xi;
    logic signed [VEC_W-1:0] yi;
    logic signed [RED_W-1:0] zi;
    logic                    pos;

    if (i == 0) begin : g_first
      assign xi = ONE_Q30;
      assign yi = '0;
      assign zi = a4;
    end else begin : g_rest
      assign xi = x_q[i];
      assign yi = y_q[i];
      assign zi = z_q[i];
    end

    assign pos = (zi >= 0);

    always_ff @(posedge clk) begin
      if (en) begin
        y_q[i+1] <= pos ? (yi + (xi >>> i)) : (yi - (xi >>> i));
      end
    end

    if (i < NS - 1) begin : g_xz
      always_ff @(posedge clk) begin
        if (en) begin
          x_q[i+1] <= pos ? (xi - (yi >>> i)) : (xi + (yi >>> i));
          z_q[i+1] <= pos ? (zi - RED_W'(atan_q30(i))) : (zi + RED_W'(atan_q30(i)));
        end
      end
    end
  end

  assign sin = SIN_W'(y_q[NS]);

endmodule

[hw/rtl/qslp_div.sv]
// Pipelined restoring divider for one weight: (num * 2^14) / den, truncated,
// saturated to +-2^24. Depends on qslp_pkg.
module qslp_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [qslp_pkg::SIN_W-1:0]  num,
  input  logic signed [qslp_pkg::SIN_W-1:0]  den,
  output logic signed [qslp_pkg::WGT_W-1:0]  w
);
  import qslp_pkg::*;

  localparam int DEN_W = SIN_W - 1;
  localparam int CMP_W = DEN_W + DIV_BITS + 1;
  localparam logic [DIV_BITS-1:0] QLIM = DIV_BITS'(WLIM);

  logic [SIN_W-1:0] num_mag;
  logic [CMP_W-1:0] nm0;
  logic [DEN_W-1:0] d0;
  logic             neg0;

  assign num_mag = num[SIN_W-1] ? SIN_W'(-num) : SIN_W'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      nm0  <= CMP_W'(num_mag) << FRAC;
      d0   <= (den < 1) ? DEN_W'(1) : den[DEN_W-1:0];
      neg0 <= num[SIN_W-1];
    end
  end

  logic [CMP_W-1:0]    r_q [1:DIV_BITS-1];
  logic [DEN_W-1:0]    d_q [1:DIV_BITS-1];
  logic [DIV_BITS-1:0] q_q [1:DIV_BITS];
  logic                n_q [1:DIV_BITS];
  logic                o_q [1:DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_bit
    localparam int B = DIV_BITS - 1 - k;
    logic [CMP_W-1:0]    ri;
    logic [CMP_W-1:0]    term;
    logic [DEN_W-1:0]    di;
    logic [DIV_BITS-1:0] qi;
    logic                ni;
    logic                ovf;
    logic                take;

    if (k == 0) begin : g_first
      assign ri  = nm0;
      assign di  = d0;
      assign qi  = '0;
      assign ni  = neg0;
      // quotient of 2^25 or more saturates anyway
      assign ovf = (nm0 >= (CMP_W'(d0) << DIV_BITS));
    end else begin : g_rest
      assign ri  = r_q[k];
      assign di  = d_q[k];
      assign qi  = q_q[k];
      assign ni  = n_q[k];
      assign ovf = o_q[k];
    end

    assign term = CMP_W'(di) << B;
    assign take = (ri >= term);

    always_ff @(posedge clk) begin
      if (en) begin
        q_q[k+1] <= take ? (qi | (DIV_BITS'(1) << B)) : qi;
        n_q[k+1] <= ni;
        o_q[k+1] <= ovf;
      end
    end

    if (k < DIV_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_q[k+1] <= take ? (ri - term) : ri;
          d_q[k+1] <= di;
        end
      end
    end
  end

  logic [DIV_BITS-1:0] qf;

  assign qf = (o_q[DIV_BITS] || (q_q[DIV_BITS] > QLIM)) ? QLIM : q_q[DIV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      w <= n_q[DIV_BITS] ? -$signed(WGT_W'(qf)) : $signed(WGT_W'(qf));
    end
  end

endmodule

[hw/rtl/quaternion_slerp_unit.sv]
// Quaternion slerp top level: input stages, sqrt/CORDIC/divide datapath,
// output blend and skid buffer. Depends on qslp_pkg and the qslp_* modules.
//
// Accepts one quaternion pair per clock while the skid register is empty and
// returns one interpolated quaternion per pair, in order. The path from input
// beat to output beat has four front stages for the dot product and cosine,
// 31 for the square root, CORDIC_STEPS each for the angle and the sines, five
// for angle reduction, 27 for the weight divide, one stage for the angle
// products, one for the blend products and the output register. The pipeline
// moves as one; a skid register behind the output register lets the block
// keep taking beats while one result waits, and it stops taking beats only
// while both hold results. near_threshold is written through cfg_*; the user
// must write it only while idle, as the block itself does not enforce this.
module quaternion_slerp_unit #(
  parameter int CORDIC_STEPS = qslp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, blend, 4 zero bits
  input  logic [151:0]                        s_axis_tdata,
  // clamp_blend
  input  logic [0:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_x, out_y, out_z, out_w
  output logic [4*qslp_pkg::OUT_W-1:0]        m_axis_tdata,
  // linear_used
  output logic [0:0]                          m_axis_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qslp_pkg::THR_W-1:0]          cfg_data
);
  import qslp_pkg::*;

  localparam int NS = steps_used(CORDIC_STEPS);
  localparam int D1 = ROOT_W + NS;
  localparam int D2 = SIN_PRE + NS + DIV_LAT;
  localparam int MUL_W = WGT_W + QN_W;
  localparam int SUM_W = MUL_W + 1;
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(524288);

  logic             en;
  logic [THR_W-1:0] near_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= THR_W'(1);
    end else if (cfg_valid) begin
      near_threshold <= cfg_data;
    end
  end

  // ---- stage 1: clamp blend, component products
  logic                               s1_valid;
  logic [3:0][COMP_W-1:0]             s1_p, s1_q;
  logic [3:0][2*COMP_W-1:0]           s1_prod;
  logic signed [BLEND_W-1:0]          s1_t;
  logic signed [BLEND_W-1:0]          t_in, t_cl;

  assign t_in = $signed(s_axis_tdata[8*COMP_W +: BLEND_W]);

  always_comb begin
    t_cl = t_in;
    if (s_axis_tuser[0]) begin
      if (t_in < 0) begin
        t_cl = '0;
      end else if (t_in > BLEND_W'(ONE_Q14)) begin
        t_cl = BLEND_W'(ONE_Q14);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_p[i]    <= s_axis_tdata[COMP_W*i +: COMP_W];
        s1_q[i]    <= s_axis_tdata[COMP_W*(4+i) +: COMP_W];
        s1_prod[i] <= $signed(s_axis_tdata[COMP_W*i +: COMP_W])
                    * $signed(s_axis_tdata[COMP_W*(4+i) +: COMP_W]);
      end
      s1_t <= t_cl;
    end
  end

  // ---- stage 2: dot product magnitude
  logic                      s2_valid, s2_neg;
  logic [3:0][COMP_W-1:0]    s2_p, s2_q;
  logic signed [BLEND_W-1:0] s2_t;
  logic [DOT_W-2:0]          s2_dabs;
  logic signed [DOT_W-1:0]   dot;

  always_comb begin
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + DOT_W'($signed(s1_prod[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p    <= s1_p;
      s2_q    <= s1_q;
      s2_t    <= s1_t;
      s2_neg  <= dot[DOT_W-1];
      s2_dabs <= (DOT_W-1)'(dot[DOT_W-1] ? -dot : dot);
    end
  end

  // ---- stage 3: cosine, path choice, flip the end quaternion
  side_t            s3_side, s3_next;
  logic [C_W-1:0]   s3_c, c_next;
  logic [DOT_W-2:0] c_full;

  assign c_full = (s2_dabs + (DOT_W-1)'(8192)) >> FRAC;
  assign c_next = (c_full > (DOT_W-1)'(ONE_Q14)) ? C_W'(ONE_Q14) : c_full[C_W-1:0];

  always_comb begin
    s3_next.valid  = s2_valid;
    s3_next.p      = s2_p;
    s3_next.t      = s2_t;
    s3_next.linear = !((C_W'(ONE_Q14) - c_next) > near_threshold);
    for (int i = 0; i < 4; i++) begin
      s3_next.q[i] = s2_neg ? QN_W'(-$signed(QN_W'($signed(s2_q[i]))))
                            : QN_W'($signed(s2_q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else if (en) begin
      s3_side <= s3_next;
      s3_c    <= c_next;
    end
  end

  // ---- stage 4: radicand (1 - c^2) in Q60
  side_t             s4_side;
  logic [RAD_W-1:0]  s4_rad;
  logic [ROOT_W-1:0] s4_cx;
  logic [2*C_W-1:0]  csq;
  logic [28:0]       one_m_csq;

  assign csq       = s3_c * s3_c;
  assign one_m_csq = 29'(1 << 28) - csq[28:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_side.valid <= 1'b0;
    end else if (en) begin
      s4_side <= s3_side;
      s4_rad  <= RAD_W'({one_m_csq, 32'b0});
      s4_cx   <= {s3_c, 16'b0};
    end
  end

  // ---- sqrt and angle
  logic [ROOT_W-1:0]       root, cx_d;
  logic signed [ANG_W-1:0] om;

  qslp_isqrt u_isqrt (
    .clk     (clk),
    .en      (en),
    .rad     (s4_rad),
    .tag_in  (s4_cx),
    .root    (root),
    .tag_out (cx_d)
  );

  qslp_atan #(.STEPS(CORDIC_STEPS)) u_atan (
    .clk  (clk),
    .en   (en),
    .x_in (cx_d),
    .y_in (root),
    .om   (om)
  );

  side_t dl1 [1:D1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= D1; k++) begin
        dl1[k].valid <= 1'b0;
      end
    end else if (en) begin
      dl1[1] <= s4_side;
      for (int k = 2; k <= D1; k++) begin
        dl1[k] <= dl1[k-1];
      end
    end
  end

  // ---- angle products
  side_t                    m_side;
  logic signed [PROD_W-1:0] m_pa, m_pb, m_po;
  logic signed [BLEND_W:0]  wa;
  logic signed [BLEND_W:0]  wb;

  assign wb = (BLEND_W+1)'($signed(dl1[D1].t));
  assign wa = (BLEND_W+1)'(ONE_Q14) - wb;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_side.valid <= 1'b0;
    end else if (en) begin
      m_side <= dl1[D1];
      m_pa   <= PROD_W'(wa) * PROD_W'(om);
      m_pb   <= PROD_W'(wb) * PROD_W'(om);
      m_po   <= PROD_W'(om) <<< FRAC;
    end
  end

  // ---- sines and weights
  logic signed [SIN_W-1:0] sin_a, sin_b, sin_om;
  logic signed [WGT_W-1:0] w0s, w1s;

  qslp_sin #(.STEPS(CORDIC_STEPS)) u_sin_a (
    .clk (clk), .en (en), .prod (m_pa), .sin (sin_a)
  );

  qslp_sin #(.STEPS(CORDIC_STEPS)) u_sin_b (
    .clk (clk), .en (en), .prod (m_pb), .sin (sin_b)
  );

  qslp_sin #(.STEPS(CORDIC_STEPS)) u_sin_om (
    .clk (clk), .en (en), .prod (m_po), .sin (sin_om)
  );

  qslp_div u_div0 (
    .clk (clk), .en (en), .num (sin_a), .den (sin_om), .w (w0s)
  );

  qslp_div u_div1 (
    .clk (clk), .en (en), .num (sin_b), .den (sin_om), .w (w1s)
  );

  side_t dl2 [1:D2];
  side_t o_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= D2; k++) begin
        dl2[k].valid <= 1'b0;
      end
    end else if (en) begin
      dl2[1] <= m_side;
      for (int k = 2; k <= D2; k++) begin
        dl2[k] <= dl2[k-1];
      end
    end
  end

  assign o_side = dl2[D2];

  // ---- weight select and blend products
  logic                    o1_valid, o1_linear;
  logic [3:0][MUL_W-1:0]   o1_pr0, o1_pr1;
  logic signed [WGT_W-1:0] w0, w1;

  assign w1 = o_side.linear ? WGT_W'($signed(o_side.t)) : w1s;
  assign w0 = o_side.linear ? (WGT_W'(ONE_Q14) - WGT_W'($signed(o_side.t))) : w0s;

  always_ff @(posedge clk) begin
    if (rst) begin
      o1_valid <= 1'b0;
    end else if (en) begin
      o1_valid <= o_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1_linear <= o_side.linear;
      for (int i = 0; i < 4; i++) begin
        o1_pr0[i] <= MUL_W'(w0) * MUL_W'($signed(o_side.p[i]));
        o1_pr1[i] <= MUL_W'(w1) * MUL_W'($signed(o_side.q[i]));
      end
    end
  end

  // ---- round, saturate, output register and skid
  logic [4*OUT_W-1:0] res;

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] r;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      sum = SUM_W'($signed(o1_pr0[i])) + SUM_W'($signed(o1_pr1[i])) + SUM_W'(8192);
      r   = sum >>> FRAC;
      if (r > OUT_MAX) begin
        r = OUT_MAX;
      end else if (r < OUT_MIN) begin
        r = OUT_MIN;
      end
      res[OUT_W*i +: OUT_W] = r[OUT_W-1:0];
    end
  end

  logic               m_valid, sk_valid, push;
  logic [4*OUT_W-1:0] m_data, sk_data;
  logic               m_lin, sk_lin;

  assign en            = !sk_valid;
  assign push          = en && o1_valid;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;
  assign m_axis_tuser  = m_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!m_valid || m_axis_tready) begin
      if (sk_valid) begin
        m_valid  <= 1'b1;
        m_data   <= sk_data;
        m_lin    <= sk_lin;
        sk_valid <= 1'b0;
      end else begin
        m_valid <= push;
        m_data  <= res;
        m_lin   <= o1_linear;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
      sk_data  <= res;
      sk_lin   <= o1_linear;
    end
  end

  // a result arriving behind a held beat must land in the skid register
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_axis_tready && push) |=> sk_valid)
    else $error("result dropped while output held");

  a_full_cos_linear: assert property (@(posedge clk) disable iff (rst)
    (s3_side.valid && s3_c == C_W'(ONE_Q14)) |-> s3_side.linear)
    else $error("cosine of one took the spherical path");

  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    (o_side.valid && !o_side.linear) |->
      (w0s <= WLIM && w0s >= -WLIM && w1s <= WLIM && w1s >= -WLIM))
    else $error("spherical weight out of range");

  a_front_enter: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid)
    else $error("accepted beat did not enter the pipeline");

endmodule

[verif/tb_quaternion_slerp_unit.sv]
// Self-checking bench for quaternion_slerp_unit: random stream traffic with a
// bit-exact slerp predictor. Depends on qslp_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_quaternion_slerp_unit;
  import qslp_pkg::*;

  localparam int STEPS = 16;
  localparam int LAT   = 70 + 2 * STEPS;

  typedef struct {
    logic signed [15:0] p [4];
    logic signed [15:0] q [4];
    logic signed [19:0] t;
    logic               clamp;
  } pair_t;

  typedef struct {
    logic [19:0] o [4];
    logic        lin;
  } slerp_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [151:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [4*OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_valid, cfg_ready;
  logic [THR_W-1:0] cfg_data;

  quaternion_slerp_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

  pair_t  pending_pairs[$];
  slerp_t expected_slerps[$];
  int     errors = 0;
  int     hold_cycles = 0;
  int     hold_req = 0;
  int     hold_done = 0;
  int     gap_cycles = 0;
  bit     drain_phase = 0;
  logic [14:0] thresh;

  longint atan_tab[24] = '{843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vec_angle(longint x, longint y);
    longint z = 0, xo;
    for (int i = 0; i < STEPS; i++) begin
      xo = x;
      if (y > 0) begin
        x += y >>> i; y -= xo >>> i; z += atan_tab[i];
      end else begin
        x -= y >>> i; y += xo >>> i; z -= atan_tab[i];
      end
    end
    return z;
  endfunction

  function automatic longint rot_sine(longint a);
    longint x = 64'sd1 << 30, y = 0, xo;
    a = a % 64'sd6746518852;
    if (a > 64'sd3373259426) a -= 64'sd6746518852;
    if (a < -64'sd3373259426) a += 64'sd6746518852;
    if (a > 64'sd1686629713) a = 64'sd3373259426 - a;
    if (a < -64'sd1686629713) a = -64'sd3373259426 - a;
    for (int i = 0; i < STEPS; i++) begin
      xo = x;
      if (a >= 0) begin
        x -= y >>> i; y += xo >>> i; a -= atan_tab[i];
      end else begin
        x += y >>> i; y -= xo >>> i; a += atan_tab[i];
      end
    end
    return y;
  endfunction

  function automatic longint ratio_q14(longint sa, longint so);
    longint w;
    if (so < 1) so = 1;
    w = (sa * 16384) / so;
    if (w > (64'sd1 << 24)) w = 64'sd1 << 24;
    if (w < -(64'sd1 << 24)) w = -(64'sd1 << 24);
    return w;
  endfunction

  function automatic slerp_t predict_slerp(pair_t it, logic [14:0] thr);
    slerp_t r;
    longint p[4], q[4], dot = 0, c, t, w0, w1, s, om, so, acc;
    longint unsigned cx;
    for (int i = 0; i < 4; i++) begin
      p[i] = it.p[i]; q[i] = it.q[i]; dot += p[i] * q[i];
    end
    t = it.t;
    if (it.clamp) begin
      if (t < 0) t = 0;
      if (t > 16384) t = 16384;
    end
    if (dot < 0) begin
      dot = -dot;
      for (int i = 0; i < 4; i++) q[i] = -q[i];
    end
    c = (dot + 8192) >>> 14;
    if (c > 16384) c = 16384;
    r.lin = !((16384 - c) > longint'(thr));
    if (r.lin) begin
      w0 = 16384 - t; w1 = t;
    end else begin
      cx = longint'(c) << 16;
      s = root_floor((64'd1 << 60) - cx * cx);
      om = vec_angle(longint'(cx), s);
      so = rot_sine(om);
      w0 = ratio_q14(rot_sine(((16384 - t) * om) >>> 14), so);
      w1 = ratio_q14(rot_sine((t * om) >>> 14), so);
    end
    for (int i = 0; i < 4; i++) begin
      acc = (w0 * p[i] + w1 * q[i] + 8192) >>> 14;
      if (acc > 524287) acc = 524287;
      if (acc < -524288) acc = -524288;
      r.o[i] = acc[19:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 32768) - 16384);
      1: return 16'($urandom);
      default: return 16'($urandom_range(0, 400) - 200);
    endcase
  endfunction

  // unit-ish quaternion pairs, near pairs, and raw noise
  function automatic pair_t rand_pair();
    pair_t it;
    int kind = $urandom_range(0, 9);
    for (int i = 0; i < 4; i++) begin
      it.p[i] = rand_comp(kind == 9 ? 1 : 0);
      it.p[i] = it.p[i] >>> 1;
      it.q[i] = (kind < 3) ? 16'(it.p[i] + $urandom_range(0, 60) - 30)
                           : rand_comp(kind == 9 ? 1 : 0) >>> (kind == 9 ? 0 : 1);
      if (kind == 1) it.q[i] = -it.q[i];
    end
    if (kind == 8) begin
      for (int i = 0; i < 4; i++) begin it.p[i] = 0; it.q[i] = 0; end
      it.p[$urandom_range(0, 3)] = 16384;
      it.q[$urandom_range(0, 3)] = ($urandom & 1) ? -16384 : 16384;
    end
    it.t = ($urandom_range(0, 5) == 0) ? 20'($urandom) : 20'($urandom_range(0, 20000) - 1800);
    it.clamp = $urandom & 1;
    return it;
  endfunction

  function automatic pair_t mk(logic [15:0] a, logic [15:0] b, logic [19:0] t, logic cl);
    pair_t it;
    for (int i = 0; i < 4; i++) begin it.p[i] = a; it.q[i] = b; end
    it.t = t; it.clamp = cl;
    return it;
  endfunction

  // driver; gap_cycles makes the occasional long idle stretch
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_cycles > 0) begin
        gap_cycles <= gap_cycles - 1;
        s_axis_tvalid <= 0;
      end else if (pending_pairs.size() > 0 && ($urandom_range(0, 3) != 0 || drain_phase)) begin
        automatic pair_t it = pending_pairs.pop_front();
        s_axis_tvalid <= 1;
        s_axis_tdata <= {4'b0, it.t, it.q[3], it.q[2], it.q[1], it.q[0],
                         it.p[3], it.p[2], it.p[1], it.p[0]};
        s_axis_tuser <= it.clamp;
        expected_slerps.push_back(predict_slerp(it, thresh));
      end else begin
        s_axis_tvalid <= 0;
        if ($urandom_range(0, 40) == 0) gap_cycles <= $urandom_range(20, 80);
      end
    end
  end

  // receiver backpressure; hold_cycles forces a long stall
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_cycles <= 400;
      m_axis_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 30) == 0) begin
      hold_cycles <= $urandom_range(5, 60);
      m_axis_tready <= 0;
    end else m_axis_tready <= ($urandom_range(0, 4) != 0);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_slerps.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        automatic slerp_t e = expected_slerps.pop_front();
        for (int i = 0; i < 4; i++)
          if (m_axis_tdata[i*20 +: 20] !== e.o[i])
            report_mismatch($sformatf("out[%0d]", i),
                            longint'($signed(m_axis_tdata[i*20 +: 20])),
                            longint'($signed(e.o[i])));
        if (m_axis_tuser[0] !== e.lin)
          report_mismatch("linear_used", m_axis_tuser[0], e.lin);
      end
    end
  end

  task automatic wait_idle();
    while (pending_pairs.size() > 0 || expected_slerps.size() > 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_thresh(logic [14:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    thresh = v;
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    automatic logic [14:0] thr_set[5] = '{15'd1, 15'd0, 15'd16384, 15'd300, 15'd30};
    rst = 1; cfg_valid = 0; cfg_data = 0; thresh = 1;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners at the reset threshold
    pending_pairs.push_back(mk(16'sd16384, 16'sd16384, 20'sd8192, 0));
    pending_pairs.push_back(mk(16'sd8192, -16'sd8192, 20'sd4096, 1));
    pending_pairs.push_back(mk(-16'sd32768, -16'sd32768, 20'sd524287, 0));
    pending_pairs.push_back(mk(-16'sd32768, 16'sd32767, -20'sd524288, 0));
    pending_pairs.push_back(mk(16'sd32767, -16'sd32768, -20'sd524288, 1));
    pending_pairs.push_back(mk(16'sd0, 16'sd0, 20'sd524287, 1));
    pending_pairs.push_back(mk(16'hFFFF, 16'h5555, 20'hAAAAA, 0));
    pending_pairs.push_back(mk(16'h0000, 16'hAAAA, 20'h55555, 1));
    begin
      automatic pair_t it = mk(0, 0, 20'sd5000, 0);
      it.p[3] = 16384; it.q[0] = 16384;  // orthogonal
      pending_pairs.push_back(it);
      it.q[0] = 11585; it.q[3] = 11585;
      pending_pairs.push_back(it);
      it.t = 20'sd60000;                 // extrapolation, large weights
      pending_pairs.push_back(it);
      it.q[0] = 16383; it.q[3] = 181;    // nearly orthogonal, sine of omega near one
      pending_pairs.push_back(it);
    end
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_thresh(thr_set[ph]);
      if (ph == 2) begin
        hold_req++;  // long stall: block fills and backpressures input
        for (int k = 0; k < 250; k++) pending_pairs.push_back(rand_pair());
      end
      for (int k = 0; k < 260; k++) pending_pairs.push_back(rand_pair());
    end
    drain_phase = 1;
    wait_idle();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
